// ===== rtl/core/telemetry_frame_checker_macros.svh =====
// Assertion macros shared by the frame checker RTL.
`ifndef TELEMETRY_FRAME_CHECKER_MACROS_SVH
`define TELEMETRY_FRAME_CHECKER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TFC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tfc assertion failed");
`define TFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tfc assertion failed");
`else
`define TFC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define TFC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/tfc_pkg.sv =====
// Types, constants and CRC function for the telemetry frame checker.
package tfc_pkg;

    localparam int FrameLen   = 22;
    localparam int CrcLen     = 20;
    localparam int StoreDepth = FrameLen - 1;
    localparam int IdxW       = 5;
    localparam int ApbAddrW   = 3;
    localparam int ApbDataW   = 32;

    localparam logic [15:0] CrcInit     = 16'hFFFF;
    localparam logic [15:0] CrcPoly     = 16'h1021;
    localparam logic [15:0] SyncReset   = 16'hAA55;
    localparam logic        RegSyncWord = 1'b0;

    localparam logic [7:0] EvNormal   = 8'h01;
    localparam logic [7:0] EvImpact   = 8'h02;
    localparam logic [7:0] EvMovement = 8'h03;

    typedef enum logic [1:0] {
        StatusOk      = 2'd0,
        StatusSyncErr = 2'd1,
        StatusCrcErr  = 2'd2
    } t_frame_status;

    typedef enum logic [1:0] {
        ClassUnknown  = 2'd0,
        ClassNormal   = 2'd1,
        ClassImpact   = 2'd2,
        ClassMovement = 2'd3
    } t_event_class;

    typedef struct packed {
        t_frame_status      frame_status;
        logic [31:0]        tx_time_ms;
        logic signed [15:0] temperature_centi;
        logic [31:0]        pressure_pa;
        logic [15:0]        altitude_cm;
        logic signed [15:0] accel_centi;
        logic signed [15:0] accel_filtered_centi;
        logic [7:0]         event_code;
        t_event_class       event_class;
        logic [15:0]        received_crc;
        logic [15:0]        computed_crc;
    } t_result;

    // CRC-16/CCITT-FALSE, one byte, MSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CrcPoly;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/tfc_ifs.sv =====
// Valid/ready channel interfaces for byte input and frame results.
interface tfc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       first_byte;

    modport source (output valid, output rx_byte, output first_byte, input ready);
    modport sink   (input valid, input rx_byte, input first_byte, output ready);
endinterface

interface tfc_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         frame_status;
    logic [31:0]        tx_time_ms;
    logic signed [15:0] temperature_centi;
    logic [31:0]        pressure_pa;
    logic [15:0]        altitude_cm;
    logic signed [15:0] accel_centi;
    logic signed [15:0] accel_filtered_centi;
    logic [7:0]         event_code;
    logic [1:0]         event_class;
    logic [15:0]        received_crc;
    logic [15:0]        computed_crc;

    modport source (
        output valid, output frame_status, output tx_time_ms, output temperature_centi,
        output pressure_pa, output altitude_cm, output accel_centi,
        output accel_filtered_centi, output event_code, output event_class,
        output received_crc, output computed_crc, input ready
    );
    modport sink (
        input valid, input frame_status, input tx_time_ms, input temperature_centi,
        input pressure_pa, input altitude_cm, input accel_centi,
        input accel_filtered_centi, input event_code, input event_class,
        input received_crc, input computed_crc, output ready
    );
endinterface

// ===== rtl/core/telemetry_frame_checker.sv =====
// Top level: telemetry frame checker with CRC-16 and field unpacking.
// Usage:
//   i_rx takes one packet byte per transfer; first_byte marks byte 0 and always
//   restarts the packet, dropping any partial one. Bytes outside a packet are
//   consumed and ignored. Each 22-byte packet gives one transfer on o_res
//   carrying status, unpacked fields and both CRC values.
//   Throughput: one byte per cycle while i_rx.ready is high; the byte-wide CRC step and the unpacking
//   of the stored bytes sit between the input and the result register.
//   Result path: the result is registered into the output register when that is free
//   or being taken, else into the skid register.
//   Stalls: a result register plus one skid entry; i_rx.ready drops only when
//   both hold results, so input keeps flowing for one stalled result.
//   Reset (synchronous, active low): closes any packet, clears the result
//   buffer and sets sync_word to 0xAA55. sync_word is at APB addresses 0 to 3.
`include "telemetry_frame_checker_macros.svh"
module telemetry_frame_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tfc_pkg::ApbAddrW-1:0] paddr,
    input  logic [tfc_pkg::ApbDataW-1:0] pwdata,
    output logic [tfc_pkg::ApbDataW-1:0] prdata,
    output logic                         pready,
    tfc_in_if.sink                       i_rx,
    tfc_out_if.source                    o_res
);
    import tfc_pkg::*;

    logic [15:0]     r_sync_word;
    logic [IdxW-1:0] r_byte_index, n_byte_index;
    logic            r_frame_active, n_frame_active;
    logic [15:0]     r_crc, n_crc;
    logic [7:0]      r_store [StoreDepth];

    logic            w_accept, w_take, w_last, w_space, w_cfg_wr;
    logic [IdxW-1:0] w_idx;
    logic [15:0]     w_crc_base, w_rx_crc, w_sync_rx;
    t_result         w_result, w_out;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = (paddr[ApbAddrW-1] == RegSyncWord) ?
                      {{(ApbDataW-16){1'b0}}, r_sync_word} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_word <= SyncReset;
        end else if (w_cfg_wr && paddr[ApbAddrW-1] == RegSyncWord) begin
            r_sync_word <= pwdata[15:0];
        end
    end

    assign i_rx.ready = w_space;
    assign w_accept   = i_rx.valid && i_rx.ready;
    assign w_take     = w_accept && (i_rx.first_byte || r_frame_active);
    assign w_idx      = i_rx.first_byte ? '0 : r_byte_index;
    assign w_crc_base = i_rx.first_byte ? CrcInit : r_crc;
    assign w_last     = w_take && (w_idx == IdxW'(FrameLen - 1));

    always_comb begin
        n_byte_index   = r_byte_index;
        n_frame_active = r_frame_active;
        n_crc          = r_crc;
        if (w_take) begin
            if (w_idx < IdxW'(CrcLen)) begin
                n_crc = crc_byte(w_crc_base, i_rx.rx_byte);
            end else begin
                n_crc = w_crc_base;
            end
            if (w_idx >= IdxW'(FrameLen - 1)) begin
                n_byte_index   = '0;
                n_frame_active = 1'b0;
            end else begin
                n_byte_index   = w_idx + 1'b1;
                n_frame_active = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_index   <= '0;
            r_frame_active <= 1'b0;
            r_crc          <= CrcInit;
        end else begin
            r_byte_index   <= n_byte_index;
            r_frame_active <= n_frame_active;
            r_crc          <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && w_idx < IdxW'(StoreDepth)) begin
            r_store[w_idx] <= i_rx.rx_byte;
        end
    end

    // last byte comes straight from the input; CRC was final after byte 19
    assign w_rx_crc  = {i_rx.rx_byte, r_store[20]};
    assign w_sync_rx = {r_store[1], r_store[0]};

    always_comb begin
        w_result.tx_time_ms           = {r_store[6], r_store[5], r_store[4], r_store[3]};
        w_result.temperature_centi    = {r_store[8], r_store[7]};
        w_result.pressure_pa          = {r_store[12], r_store[11], r_store[10], r_store[9]};
        w_result.altitude_cm          = {r_store[14], r_store[13]};
        w_result.accel_centi          = {r_store[16], r_store[15]};
        w_result.accel_filtered_centi = {r_store[18], r_store[17]};
        w_result.event_code           = r_store[19];
        w_result.received_crc         = w_rx_crc;
        w_result.computed_crc         = r_crc;
        unique case (r_store[19])
            EvNormal:   w_result.event_class = ClassNormal;
            EvImpact:   w_result.event_class = ClassImpact;
            EvMovement: w_result.event_class = ClassMovement;
            default:    w_result.event_class = ClassUnknown;
        endcase
        priority if (w_sync_rx != r_sync_word) begin
            w_result.frame_status = StatusSyncErr;
        end else if (w_rx_crc != r_crc) begin
            w_result.frame_status = StatusCrcErr;
        end else begin
            w_result.frame_status = StatusOk;
        end
    end

    tfc_out_skid u_out_skid (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_last),
        .i_result (w_result),
        .o_space  (w_space),
        .o_valid  (o_res.valid),
        .i_ready  (o_res.ready),
        .o_result (w_out)
    );

    assign o_res.frame_status         = w_out.frame_status;
    assign o_res.tx_time_ms           = w_out.tx_time_ms;
    assign o_res.temperature_centi    = w_out.temperature_centi;
    assign o_res.pressure_pa          = w_out.pressure_pa;
    assign o_res.altitude_cm          = w_out.altitude_cm;
    assign o_res.accel_centi          = w_out.accel_centi;
    assign o_res.accel_filtered_centi = w_out.accel_filtered_centi;
    assign o_res.event_code           = w_out.event_code;
    assign o_res.event_class          = w_out.event_class;
    assign o_res.received_crc         = w_out.received_crc;
    assign o_res.computed_crc         = w_out.computed_crc;

    `TFC_ASSERT_IMPLIES(a_idle_index, i_clk, i_rst_n, !r_frame_active, r_byte_index == '0)
    `TFC_ASSERT_IMPLIES(a_index_range, i_clk, i_rst_n, r_frame_active, r_byte_index < IdxW'(FrameLen))
    `TFC_ASSERT_NEXT(a_result_shows, i_clk, i_rst_n, w_last, o_res.valid)
    `TFC_ASSERT_IMPLIES(a_ok_crc_match, i_clk, i_rst_n,
        o_res.valid && o_res.frame_status == StatusOk, o_res.received_crc == o_res.computed_crc)

endmodule

// ===== rtl/core/tfc_out_skid.sv =====
// Two-entry result buffer: output register plus skid register.
module tfc_out_skid (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  tfc_pkg::t_result i_result,
    output logic             o_space,
    output logic             o_valid,
    input  logic             i_ready,
    output tfc_pkg::t_result o_result
);
    import tfc_pkg::*;

    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out, n_out;
    t_result r_skid, n_skid;
    logic    w_pop;

    assign w_pop = r_out_valid && i_ready;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (!r_out_valid || w_pop) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out       = i_result;
                n_out_valid = i_push;
            end
        end else if (i_push) begin
            n_skid       = i_result;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_space  = !r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule
